>>> rtl/sart_pkg.sv
`default_nettype none

package sart_pkg;

    // Table size and derived widths
    localparam int MAX_RULES = 64;
    localparam int ADDR_W    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int COUNT_W   = $clog2(MAX_RULES + 1);
    localparam int IP_W      = 32;

    // Command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // Status codes
    localparam logic STS_OK   = 1'b0;
    localparam logic STS_FULL = 1'b1;

    // One stored rule, kept as a single memory word
    typedef struct packed {
        logic [IP_W-1:0] src_net;
        logic [IP_W-1:0] src_netmask;
        logic [IP_W-1:0] dst_subnet;
        logic [IP_W-1:0] dst_mask;
        logic            allow;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    // Compare unit verdict
    typedef struct packed {
        logic hit;
        logic permit;
    } match_t;

endpackage

`default_nettype wire

>>> rtl/sart_ram.sv
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data
module sart_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sart_match.sv
`default_nettype none

// Shared rule compare unit: masks both addresses with one rule and checks them
module sart_match (
    input  wire sart_pkg::rule_t         rule,
    input  wire logic [sart_pkg::IP_W-1:0] src_addr,
    input  wire logic [sart_pkg::IP_W-1:0] dst_addr,
    output sart_pkg::match_t             result
);

    import sart_pkg::*;

    logic src_ok;
    logic dst_ok;

    // Masked compare on each side
    assign src_ok = ((src_addr & rule.src_netmask) == rule.src_net);
    assign dst_ok = ((dst_addr & rule.dst_mask) == rule.dst_subnet);

    assign result.hit    = src_ok && dst_ok;
    assign result.permit = rule.allow;

endmodule

`default_nettype wire

>>> rtl/subnet_access_rule_table.sv
`default_nettype none

// First-match IPv4 access list holding up to MAX_RULES rules in one rule memory.
// An append (command 0) stores the masked source and destination subnets, both
// masks and the allow bit; its result follows in the cycle after acceptance, with
// status 1 and nothing stored when the table is full. A check (command 1) reads
// the rules oldest first through the memory's single read port, one rule per
// cycle into one shared compare unit, and stops at the first hit or after the
// last stored rule; an empty table is answered without a scan. The block takes
// one transaction at a time; in_stall stays high from acceptance until the
// result transaction has been taken.
module subnet_access_rule_table (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Input channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    command,
    input  wire logic [sart_pkg::IP_W-1:0] src_addr,
    input  wire logic [sart_pkg::IP_W-1:0] src_netmask,
    input  wire logic [sart_pkg::IP_W-1:0] dst_addr,
    input  wire logic [sart_pkg::IP_W-1:0] dst_mask,
    input  wire logic                    allow,
    // Result channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         permitted,
    output logic                         status
);

    import sart_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IP_W-1:0]    src_reg, src_next;
    logic [IP_W-1:0]    dst_reg, dst_next;
    logic               permitted_reg, permitted_next;
    logic               status_reg, status_next;

    logic               in_accept;
    logic               full;
    logic               issue;
    logic               wr_en;
    rule_t              wr_rule;
    logic [RULE_W-1:0]  rd_word;
    rule_t              rd_rule;
    match_t             match;

    assign in_accept = in_valid && !in_stall;
    assign full      = (count_reg == COUNT_W'(MAX_RULES));
    assign issue     = (state_reg == ST_SCAN) && (rd_idx_reg != count_reg);

    // New rule word, stored at the acceptance edge
    assign wr_en               = in_accept && (command == CMD_APPEND) && !full;
    assign wr_rule.src_net     = src_addr & src_netmask;
    assign wr_rule.src_netmask = src_netmask;
    assign wr_rule.dst_subnet  = dst_addr & dst_mask;
    assign wr_rule.dst_mask    = dst_mask;
    assign wr_rule.allow       = allow;

    sart_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES)
    ) u_rule_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_rule),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_word)
    );

    assign rd_rule = rule_t'(rd_word);

    sart_match u_match (
        .rule     (rd_rule),
        .src_addr (src_reg),
        .dst_addr (dst_reg),
        .result   (match)
    );

    // Sequencer: accept, scan one rule per cycle, hold result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        permitted_next = permitted_reg;
        status_next    = status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    permitted_next = 1'b0;
                    status_next    = STS_OK;
                    if (command == CMD_APPEND)
                    begin
                        if (full)
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        src_next       = src_addr;
                        dst_next       = dst_addr;
                        rd_idx_next    = '0;
                        cmp_valid_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                cmp_valid_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + COUNT_W'(1);
                end
                if (cmp_valid_reg && match.hit)
                begin
                    permitted_next = match.permit;
                    state_next     = ST_RESP;
                end
                else if (cmp_valid_reg && !issue)
                begin
                    permitted_next = 1'b0;
                    state_next     = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        permitted_reg <= permitted_next;
        status_reg    <= status_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);
    assign permitted = permitted_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // Only one transaction in flight: a pending result blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result pending while input is open");

    // Rule count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_RULES))
        else $error("rule count overflow");

    // Append to a full table is refused and leaves the count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (command == CMD_APPEND) && full)
            |=> (out_valid && (status == STS_FULL) && $stable(count_reg)))
        else $error("append to full table not refused");

    // A refused append never reports a permit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STS_FULL)) |-> !permitted)
        else $error("permit with full status");
`endif

endmodule

`default_nettype wire

>>> bench/tb_subnet_access_rule_table.sv
module tb_subnet_access_rule_table;
    import sart_pkg::*;

    localparam int DIRECTED_ITEMS = 17;
    localparam int RANDOM_ITEMS   = 950;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = MAX_RULES + 16;

    // One input transaction, one field per port
    typedef struct packed {
        logic            cmd;
        logic [IP_W-1:0] sa;
        logic [IP_W-1:0] sm;
        logic [IP_W-1:0] da;
        logic [IP_W-1:0] dm;
        logic            alw;
    } acl_item_t;

    typedef struct packed {
        logic permit;
        logic sts;
    } verdict_t;

    // Directed row: transaction plus an optional hand-written verdict
    typedef struct packed {
        acl_item_t item;
        logic      typed;
        verdict_t  want;
    } directed_row_t;

    localparam verdict_t DENY_OK = '{1'b0, STS_OK};

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            in_valid    = 1'b0;
    logic            command     = CMD_APPEND;
    logic [IP_W-1:0] src_addr    = '0;
    logic [IP_W-1:0] src_netmask = '0;
    logic [IP_W-1:0] dst_addr    = '0;
    logic [IP_W-1:0] dst_mask    = '0;
    logic            allow       = 1'b0;
    logic            out_stall   = 1'b0;
    logic            in_stall;
    logic            out_valid;
    logic            permitted;
    logic            status;

    // Shadow copy of the rule table
    logic [IP_W-1:0] acl_src_net  [MAX_RULES];
    logic [IP_W-1:0] acl_smask    [MAX_RULES];
    logic [IP_W-1:0] acl_dst_net  [MAX_RULES];
    logic [IP_W-1:0] acl_dst_mask [MAX_RULES];
    logic            acl_allow    [MAX_RULES];
    int              acl_count = 0;

    verdict_t        pending_verdicts[$];
    directed_row_t   plan [DIRECTED_ITEMS];

    int error_count = 0;
    int cycle_count = 0;
    int n_appends   = 0;
    int n_refused   = 0;
    int n_checks    = 0;
    int n_permits   = 0;
    int stall_left  = 3;
    bit send_calm   = 1'b0;
    bit recv_calm   = 1'b0;
    int i;

    always #5 clk = ~clk;

    subnet_access_rule_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .src_addr    (src_addr),
        .src_netmask (src_netmask),
        .dst_addr    (dst_addr),
        .dst_mask    (dst_mask),
        .allow       (allow),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .permitted   (permitted),
        .status      (status)
    );

    // First-match verdict; appends update the shadow table
    function automatic verdict_t predict_verdict(acl_item_t it);
        verdict_t v;
        logic     hit;
        v   = DENY_OK;
        hit = 1'b0;
        if (it.cmd == CMD_APPEND)
        begin
            n_appends++;
            if (acl_count >= MAX_RULES)
            begin
                v.sts = STS_FULL;
                n_refused++;
            end
            else
            begin
                acl_src_net[acl_count]  = it.sa & it.sm;
                acl_smask[acl_count]    = it.sm;
                acl_dst_net[acl_count]  = it.da & it.dm;
                acl_dst_mask[acl_count] = it.dm;
                acl_allow[acl_count]    = it.alw;
                acl_count++;
            end
        end
        else
        begin
            n_checks++;
            for (int k = 0; k < acl_count; k++)
            begin
                if (!hit && (it.sa & acl_smask[k]) == acl_src_net[k]
                         && (it.da & acl_dst_mask[k]) == acl_dst_net[k])
                begin
                    hit      = 1'b1;
                    v.permit = acl_allow[k];
                end
            end
            if (v.permit)
                n_permits++;
        end
        return v;
    endfunction

    // Mostly prefix masks, some short prefixes and some arbitrary bit patterns
    function automatic logic [IP_W-1:0] random_mask();
        int              len;
        logic [IP_W-1:0] ones;
        ones = '1;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       len = $urandom_range(0, 7);
            default: len = $urandom_range(8, 32);
        endcase
        return ones << (IP_W - len);
    endfunction

    // Appends, checks aimed at a stored rule, near misses and plain noise
    function automatic acl_item_t random_item();
        acl_item_t it;
        int        pick;
        int        k;
        it.cmd = CMD_CHECK;
        it.sa  = $urandom;
        it.sm  = $urandom;
        it.da  = $urandom;
        it.dm  = $urandom;
        it.alw = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 99);
        if (pick < 13)
        begin
            it.cmd = CMD_APPEND;
            it.sm  = random_mask();
            it.dm  = random_mask();
        end
        else if (pick < 78 && acl_count > 0)
        begin
            k     = $urandom_range(0, acl_count - 1);
            it.sa = acl_src_net[k] | (it.sa & ~acl_smask[k]);
            it.da = acl_dst_net[k] | (it.da & ~acl_dst_mask[k]);
            // near miss: flip the lowest compared bit
            if (pick >= 63)
            begin
                if (acl_dst_mask[k] != '0)
                    it.da ^= acl_dst_mask[k] & (~acl_dst_mask[k] + 1'b1);
                else
                    it.sa ^= acl_smask[k] & (~acl_smask[k] + 1'b1);
            end
        end
        return it;
    endfunction

    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        return send_calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Hold the transaction until accepted, then record its verdict
    task automatic send_transaction(acl_item_t it, logic typed, verdict_t want);
        verdict_t v;
        command     <= it.cmd;
        src_addr    <= it.sa;
        src_netmask <= it.sm;
        dst_addr    <= it.da;
        dst_mask    <= it.dm;
        allow       <= it.alw;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        v = predict_verdict(it);
        pending_verdicts = {pending_verdicts, (typed ? want : v)};
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Result side: random stall per transaction, compare against oldest verdict
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with nothing pending, permitted %0b status %0b",
                             $time, permitted, status);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (permitted !== want.permit)
                    begin
                        error_count++;
                        $display("%0t: permitted mismatch, expected %0b, actual %0b",
                                 $time, want.permit, permitted);
                    end
                    if (status !== want.sts)
                    begin
                        error_count++;
                        $display("%0t: status mismatch, expected %0b, actual %0b",
                                 $time, want.sts, status);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                stall_left = recv_calm ? 0 : $urandom_range(0, 8);
            end
            else if (out_valid === 1'b1 && stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_verdicts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        // empty table, then rule shapes, first-match order and mask handling
        plan[0]  = '{'{CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b1}, 1'b1, DENY_OK};
        plan[1]  = '{'{CMD_CHECK,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                       32'h0000_0000, 1'b0}, 1'b1, DENY_OK};
        plan[2]  = '{'{CMD_APPEND, 32'h0A01_02FF, 32'hFF00_0000, 32'hC0A8_0163,
                       32'hFFFF_FF00, 1'b1}, 1'b1, DENY_OK};
        plan[3]  = '{'{CMD_CHECK,  32'h0A09_0909, 32'h0000_0000, 32'hC0A8_01FE,
                       32'h0000_0000, 1'b0}, 1'b0, DENY_OK};
        plan[4]  = '{'{CMD_CHECK,  32'h0A09_0909, 32'hFFFF_FFFF, 32'hC0A8_02FE,
                       32'hFFFF_FFFF, 1'b1}, 1'b0, DENY_OK};
        plan[5]  = '{'{CMD_CHECK,  32'h0B00_0000, 32'h0000_0000, 32'hC0A8_0101,
                       32'h0000_0000, 1'b0}, 1'b0, DENY_OK};
        plan[6]  = '{'{CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b0}, 1'b1, DENY_OK};
        plan[7]  = '{'{CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h0000_0000, 1'b1}, 1'b0, DENY_OK};
        // source and destination masks differ: catches a swapped mask store
        plan[8]  = '{'{CMD_APPEND, 32'hDEAD_BEEF, 32'hFFFF_0000, 32'h1234_5678,
                       32'hFF00_FF00, 1'b1}, 1'b1, DENY_OK};
        plan[9]  = '{'{CMD_CHECK,  32'hDEAD_0000, 32'h0000_0000, 32'h12AB_56CD,
                       32'h0000_0000, 1'b0}, 1'b0, DENY_OK};
        plan[10] = '{'{CMD_CHECK,  32'hDEAD_FFFF, 32'h0000_0000, 32'h12AB_57CD,
                       32'h0000_0000, 1'b0}, 1'b0, DENY_OK};
        // shadowed duplicate with opposite verdict
        plan[11] = '{'{CMD_APPEND, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0100,
                       32'hFFFF_FF00, 1'b0}, 1'b1, DENY_OK};
        plan[12] = '{'{CMD_CHECK,  32'h0A7F_7F7F, 32'h0000_0000, 32'hC0A8_0101,
                       32'h0000_0000, 1'b0}, 1'b0, DENY_OK};
        // any source toward one host
        plan[13] = '{'{CMD_APPEND, 32'h5555_5555, 32'h0000_0000, 32'h0000_0000,
                       32'hFFFF_FFFF, 1'b1}, 1'b1, DENY_OK};
        plan[14] = '{'{CMD_CHECK,  32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000,
                       32'h0000_0000, 1'b0}, 1'b0, DENY_OK};
        // single-bit masks
        plan[15] = '{'{CMD_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                       32'h0000_0001, 1'b0}, 1'b1, DENY_OK};
        plan[16] = '{'{CMD_CHECK,  32'h8000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h0000_0000, 1'b1}, 1'b0, DENY_OK};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ITEMS; i++)
        begin
            send_transaction(plan[i].item, plan[i].typed, plan[i].want);
            pause_sender(draw_gap());
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // mid-run hold-off until the block has drained
            if (i == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_verdicts.size() != 0);
            end
            send_transaction(random_item(), 1'b0, DENY_OK);
            pause_sender(draw_gap());
        end

        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d appends (%0d turned away by a full table) and %0d checks,",
                 n_appends, n_refused, n_checks);
        $display("%0d of them permitted, against %0d stored rules, with random gaps and stalls.",
                 n_permits, acl_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
